[hdl/rgb_to_hsv_assert.svh]
// ----------------------------------------------------------------------------
// rgb_to_hsv assertion macros
// Concurrent assertion wrappers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef RGB_TO_HSV_ASSERT_SVH
`define RGB_TO_HSV_ASSERT_SVH
`ifndef SYNTHESIS
`define RTH_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rgb_to_hsv: assertion failed");
`define RTH_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rgb_to_hsv: assertion failed");
`else
`define RTH_ASSERT_IMPL(label, clk, rst, ante, cons)
`define RTH_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

[hdl/rth_pkg.sv]
// ----------------------------------------------------------------------------
// rth_pkg
// Shared widths, constants and types of the RGB to HSV converter.
// ----------------------------------------------------------------------------
package rth_pkg;

   localparam int CHAN_W         = 8;
   localparam int HUE_W          = 15;
   localparam int INNER_W        = 11;  // sector numerator, up to 6*255
   localparam int PROD_W         = 17;  // 60 * sector numerator
   localparam int SAT_NUM_W      = 16;  // delta*255 + max/2
   localparam int DEG_PER_SECTOR = 60;
   localparam int DEG_FULL       = 360;
   localparam int HUE_SECTORS    = 6;
   localparam int GREEN_BASE     = 2;
   localparam int BLUE_BASE      = 4;
   localparam int SAT_SCALE      = 255;

   typedef enum logic [1:0] {
      SECTOR_RED,
      SECTOR_GREEN,
      SECTOR_BLUE
   } sector_type;

   typedef struct packed {
      logic advance;
      logic valid;
   } pipe_ctl_type;

endpackage

[hdl/rth_div.sv]
// ----------------------------------------------------------------------------
// rth_div
// Two-lane pipelined restoring divider, one quotient bit per stage, with a
// sideband that travels alongside. The whole pipe moves on advance.
// ----------------------------------------------------------------------------
module rth_div #(
   parameter int QUO_W  = 15,
   parameter int A_W    = 23,
   parameter int B_W    = 16,
   parameter int SIDE_W = 9
) (
   input  logic                        clock,
   input  logic                        reset,
   input  rth_pkg::pipe_ctl_type       ctl,
   input  logic [A_W-1:0]              a_num,
   input  logic [rth_pkg::CHAN_W-1:0]  a_den,
   input  logic [B_W-1:0]              b_num,
   input  logic [rth_pkg::CHAN_W-1:0]  b_den,
   input  logic [SIDE_W-1:0]           side,
   output logic                        valid_out,
   output logic [QUO_W-1:0]            a_quo,
   output logic [QUO_W-1:0]            b_quo,
   output logic [SIDE_W-1:0]           side_out
);
   import rth_pkg::*;

   localparam int AR_W = (A_W > CHAN_W + QUO_W) ? A_W : CHAN_W + QUO_W;
   localparam int BR_W = (B_W > CHAN_W + QUO_W) ? B_W : CHAN_W + QUO_W;

   logic [QUO_W-1:0]  valid_ff;
   logic [AR_W-1:0]   a_rem_ff [QUO_W];
   logic [BR_W-1:0]   b_rem_ff [QUO_W];
   logic [CHAN_W-1:0] a_den_ff [QUO_W];
   logic [CHAN_W-1:0] b_den_ff [QUO_W];
   logic [QUO_W-1:0]  a_quo_ff [QUO_W];
   logic [QUO_W-1:0]  b_quo_ff [QUO_W];
   logic [SIDE_W-1:0] side_ff  [QUO_W];

   for (genvar i = 0; i < QUO_W; i++) begin : g_stage
      localparam int K = QUO_W - 1 - i;

      logic              valid_cur;
      logic [AR_W-1:0]   a_rem_cur, a_shift;
      logic [BR_W-1:0]   b_rem_cur, b_shift;
      logic [CHAN_W-1:0] a_den_cur, b_den_cur;
      logic [QUO_W-1:0]  a_quo_cur, b_quo_cur;
      logic [SIDE_W-1:0] side_cur;
      logic              a_take, b_take;

      if (i == 0) begin : g_first
         assign valid_cur = ctl.valid;
         assign a_rem_cur = AR_W'(a_num);
         assign b_rem_cur = BR_W'(b_num);
         assign a_den_cur = a_den;
         assign b_den_cur = b_den;
         assign a_quo_cur = '0;
         assign b_quo_cur = '0;
         assign side_cur  = side;
      end else begin : g_next
         assign valid_cur = valid_ff[i-1];
         assign a_rem_cur = a_rem_ff[i-1];
         assign b_rem_cur = b_rem_ff[i-1];
         assign a_den_cur = a_den_ff[i-1];
         assign b_den_cur = b_den_ff[i-1];
         assign a_quo_cur = a_quo_ff[i-1];
         assign b_quo_cur = b_quo_ff[i-1];
         assign side_cur  = side_ff[i-1];
      end

      always_comb begin
         a_shift = AR_W'(a_den_cur) << K;
         b_shift = BR_W'(b_den_cur) << K;
         a_take  = a_rem_cur >= a_shift;
         b_take  = b_rem_cur >= b_shift;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i] <= 1'b0;
         end else if (ctl.advance) begin
            valid_ff[i] <= valid_cur;
         end
      end

      always_ff @(posedge clock) begin
         if (ctl.advance) begin
            a_rem_ff[i]    <= a_take ? a_rem_cur - a_shift : a_rem_cur;
            b_rem_ff[i]    <= b_take ? b_rem_cur - b_shift : b_rem_cur;
            a_quo_ff[i]    <= a_quo_cur | (QUO_W'(a_take) << K);
            b_quo_ff[i]    <= b_quo_cur | (QUO_W'(b_take) << K);
            a_den_ff[i]    <= a_den_cur;
            b_den_ff[i]    <= b_den_cur;
            side_ff[i]     <= side_cur;
         end
      end
   end

   assign valid_out = valid_ff[QUO_W-1];
   assign a_quo     = a_quo_ff[QUO_W-1];
   assign b_quo     = b_quo_ff[QUO_W-1];
   assign side_out  = side_ff[QUO_W-1];

endmodule

[hdl/rgb_to_hsv.sv]
// ----------------------------------------------------------------------------
// rgb_to_hsv
// Pipelined conversion of 8-bit RGB pixels to fixed-point HSV.
// ----------------------------------------------------------------------------
// Takes one pixel per clock unless the output stalls, and returns one result per
// pixel, in order. The pipe has three front stages (max/min and sector, sector
// numerator, scaled dividends), one stage per hue quotient bit in the shared
// divider pipe that also forms saturation, and the output register. When
// rsp_ready is low with a result waiting, the whole pipe holds and req_ready
// drops in the same cycle.
// Black and gray pixels give hue 0, saturation 0 and hue_undefined set.
`include "rgb_to_hsv_assert.svh"

module rgb_to_hsv #(
   parameter int HUE_FRAC_BITS = 6
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [rth_pkg::CHAN_W-1:0]  req_red_in,
   input  logic [rth_pkg::CHAN_W-1:0]  req_green_in,
   input  logic [rth_pkg::CHAN_W-1:0]  req_blue_in,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [rth_pkg::HUE_W-1:0]   rsp_hue_out,
   output logic [rth_pkg::CHAN_W-1:0]  rsp_saturation_out,
   output logic [rth_pkg::CHAN_W-1:0]  rsp_value_out,
   output logic                        rsp_hue_undefined
);
   import rth_pkg::*;

   localparam int QUO_W     = 9 + HUE_FRAC_BITS;
   localparam int HUE_NUM_W = PROD_W + HUE_FRAC_BITS;
   localparam int SIDE_W    = CHAN_W + 1;
   localparam logic [QUO_W-1:0] HUE_FULL = QUO_W'(DEG_FULL) << HUE_FRAC_BITS;

   logic advance;

   // stage 1: max, min, sector
   logic              s1_valid_ff;
   logic [CHAN_W-1:0] s1_red_ff, s1_green_ff, s1_blue_ff, s1_max_ff, s1_min_ff;
   sector_type        s1_sector_ff;
   logic [CHAN_W-1:0] s1_max_in, s1_min_in;
   sector_type        s1_sector_in;

   always_comb begin
      if (req_red_in >= req_green_in && req_red_in >= req_blue_in) begin
         s1_sector_in = SECTOR_RED;
         s1_max_in    = req_red_in;
      end else if (req_green_in >= req_blue_in) begin
         s1_sector_in = SECTOR_GREEN;
         s1_max_in    = req_green_in;
      end else begin
         s1_sector_in = SECTOR_BLUE;
         s1_max_in    = req_blue_in;
      end
      s1_min_in = (req_red_in <= req_green_in) ? req_red_in : req_green_in;
      if (req_blue_in < s1_min_in) begin
         s1_min_in = req_blue_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_red_ff    <= req_red_in;
         s1_green_ff  <= req_green_in;
         s1_blue_ff   <= req_blue_in;
         s1_max_ff    <= s1_max_in;
         s1_min_ff    <= s1_min_in;
         s1_sector_ff <= s1_sector_in;
      end
   end

   // stage 2: delta and sector numerator in units of 60 degrees
   logic               s2_valid_ff, s2_undef_ff;
   logic [CHAN_W-1:0]  s2_delta_ff, s2_max_ff;
   logic [INNER_W-1:0] s2_inner_ff;
   logic [CHAN_W-1:0]  s2_delta_in;
   logic [INNER_W-1:0] s2_inner_in, r_w, g_w, b_w, d_w;

   always_comb begin
      s2_delta_in = s1_max_ff - s1_min_ff;
      r_w = INNER_W'(s1_red_ff);
      g_w = INNER_W'(s1_green_ff);
      b_w = INNER_W'(s1_blue_ff);
      d_w = INNER_W'(s2_delta_in);
      unique case (s1_sector_ff)
         SECTOR_RED: begin
            if (g_w >= b_w) begin
               s2_inner_in = g_w - b_w;
            end else begin
               s2_inner_in = d_w * INNER_W'(HUE_SECTORS) - (b_w - g_w);
            end
         end
         SECTOR_GREEN: s2_inner_in = d_w * INNER_W'(GREEN_BASE) + b_w - r_w;
         SECTOR_BLUE:  s2_inner_in = d_w * INNER_W'(BLUE_BASE) + r_w - g_w;
         default:      s2_inner_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_delta_ff <= s2_delta_in;
         s2_max_ff   <= s1_max_ff;
         s2_inner_ff <= s2_inner_in;
         s2_undef_ff <= (s2_delta_in == '0);
      end
   end

   // stage 3: rounded dividends
   logic                 s3_valid_ff, s3_undef_ff;
   logic [CHAN_W-1:0]    s3_delta_ff, s3_max_ff;
   logic [HUE_NUM_W-1:0] s3_hue_num_ff, s3_hue_num_in;
   logic [SAT_NUM_W-1:0] s3_sat_num_ff, s3_sat_num_in;

   always_comb begin
      s3_hue_num_in = ((HUE_NUM_W'(s2_inner_ff) * HUE_NUM_W'(DEG_PER_SECTOR))
                       << HUE_FRAC_BITS) + HUE_NUM_W'(s2_delta_ff >> 1);
      s3_sat_num_in = SAT_NUM_W'(s2_delta_ff) * SAT_NUM_W'(SAT_SCALE)
                      + SAT_NUM_W'(s2_max_ff >> 1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (advance) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s3_hue_num_ff <= s3_hue_num_in;
         s3_sat_num_ff <= s3_sat_num_in;
         s3_delta_ff   <= s2_delta_ff;
         s3_max_ff     <= s2_max_ff;
         s3_undef_ff   <= s2_undef_ff;
      end
   end

   // divider pipe
   pipe_ctl_type      div_ctl;
   logic              div_valid;
   logic [QUO_W-1:0]  div_hue_quo, div_sat_quo;
   logic [SIDE_W-1:0] div_side;

   assign div_ctl.advance = advance;
   assign div_ctl.valid   = s3_valid_ff;

   rth_div #(
      .QUO_W  (QUO_W),
      .A_W    (HUE_NUM_W),
      .B_W    (SAT_NUM_W),
      .SIDE_W (SIDE_W)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .ctl       (div_ctl),
      .a_num     (s3_hue_num_ff),
      .a_den     (s3_delta_ff),
      .b_num     (s3_sat_num_ff),
      .b_den     (s3_max_ff),
      .side      ({s3_max_ff, s3_undef_ff}),
      .valid_out (div_valid),
      .a_quo     (div_hue_quo),
      .b_quo     (div_sat_quo),
      .side_out  (div_side)
   );

   // output register
   logic              out_valid_ff, out_undef_ff;
   logic [HUE_W-1:0]  out_hue_ff, out_hue_in;
   logic [CHAN_W-1:0] out_sat_ff, out_sat_in, out_value_ff;
   logic [QUO_W-1:0]  hue_wrap;
   logic              div_undef;

   assign advance   = !out_valid_ff || rsp_ready;
   assign div_undef = div_side[0];

   always_comb begin
      hue_wrap   = (div_hue_quo >= HUE_FULL) ? div_hue_quo - HUE_FULL : div_hue_quo;
      out_hue_in = div_undef ? '0 : HUE_W'(hue_wrap);
      out_sat_in = div_undef ? '0 : CHAN_W'(div_sat_quo);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= div_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_hue_ff   <= out_hue_in;
         out_sat_ff   <= out_sat_in;
         out_value_ff <= div_side[SIDE_W-1:1];
         out_undef_ff <= div_undef;
      end
   end

   assign req_ready          = advance;
   assign rsp_valid          = out_valid_ff;
   assign rsp_hue_out        = out_hue_ff;
   assign rsp_saturation_out = out_sat_ff;
   assign rsp_value_out      = out_value_ff;
   assign rsp_hue_undefined  = out_undef_ff;

   `RTH_ASSERT_IMPL(a_undef_zero, clock, reset, rsp_valid && rsp_hue_undefined, rsp_hue_out == '0 && rsp_saturation_out == '0)
   `RTH_ASSERT_IMPL(a_hue_range, clock, reset, rsp_valid, rsp_hue_out < HUE_FULL)
   `RTH_ASSERT_IMPL(a_color_nonzero, clock, reset, rsp_valid && !rsp_hue_undefined, rsp_saturation_out != '0 && rsp_value_out != '0)
   `RTH_ASSERT_IMPL(a_stall_source, clock, reset, !req_ready, rsp_valid && !rsp_ready)
   `RTH_ASSERT_NEXT(a_no_phantom, clock, reset, !div_valid && (!rsp_valid || rsp_ready), !rsp_valid)

endmodule

[test/rgb_to_hsv_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_to_hsv_test
// Self-checking bench for the RGB to HSV converter. Pixels flow from a queue
// through a valid/ready driver. Each accepted pixel is run through a local
// fixed-point HSV predictor. Results are compared field by field, in order.
// Both sides idle in random bursts, and one long output stall backs up the
// pipe. Directed corner pixels come first, then shaped random pixels.
// ----------------------------------------------------------------------------
module rgb_to_hsv_test;
   import rth_pkg::*;

   localparam int HUE_FRAC    = 6;
   localparam int RANDOM_PIX  = 1500;
   localparam int TAIL_QUIET  = 150;
   localparam int LONG_HOLD   = 240;
   localparam int HOLD_AFTER  = 300;
   localparam int DRAIN_CYC   = 60;
   localparam int MAX_CYCLES  = 200000;

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
   } pixel_type;

   typedef struct packed {
      logic [HUE_W-1:0]  hue;
      logic [CHAN_W-1:0] sat;
      logic [CHAN_W-1:0] val;
      logic              undef;
   } hsv_result_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic [CHAN_W-1:0] req_red_in = '0;
   logic [CHAN_W-1:0] req_green_in = '0;
   logic [CHAN_W-1:0] req_blue_in = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic [HUE_W-1:0]  rsp_hue_out;
   logic [CHAN_W-1:0] rsp_saturation_out;
   logic [CHAN_W-1:0] rsp_value_out;
   logic              rsp_hue_undefined;

   pixel_type      pixel_queue[$];
   hsv_result_type expected_hsv[$];
   int             pixels_total = 0;
   int             pixels_sent = 0;
   int             results_seen = 0;
   int             undefined_seen = 0;
   int             mismatches = 0;
   int             send_gap = 0;
   int             hold_left = 0;
   int             cycle_count = 0;
   bit             tail_quiet = 1'b0;
   bit             long_hold_done = 1'b0;

   rgb_to_hsv #(
      .HUE_FRAC_BITS(HUE_FRAC)
   ) u_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_red_in(req_red_in),
      .req_green_in(req_green_in),
      .req_blue_in(req_blue_in),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_hue_out(rsp_hue_out),
      .rsp_saturation_out(rsp_saturation_out),
      .rsp_value_out(rsp_value_out),
      .rsp_hue_undefined(rsp_hue_undefined)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic hsv_result_type predict_hsv(pixel_type px);
      int unsigned    r, g, b, hi, lo, span, numer, hue_fx, sat_fx;
      sector_type     sector;
      hsv_result_type res;
      r = 32'(px.red);
      g = 32'(px.green);
      b = 32'(px.blue);
      hi = r;
      if (g > hi) hi = g;
      if (b > hi) hi = b;
      lo = r;
      if (g < lo) lo = g;
      if (b < lo) lo = b;
      span = hi - lo;
      res.val = hi[CHAN_W-1:0];
      res.hue = '0;
      res.sat = '0;
      res.undef = 1'b1;
      if (hi != 0 && span != 0) begin
         sat_fx = (span * SAT_SCALE + hi / 2) / hi;
         if (r == hi) sector = SECTOR_RED;
         else if (g == hi) sector = SECTOR_GREEN;
         else sector = SECTOR_BLUE;
         case (sector)
            SECTOR_RED: numer = (g >= b) ? g - b : HUE_SECTORS * span - (b - g);
            SECTOR_GREEN: numer = GREEN_BASE * span + b - r;
            default: numer = BLUE_BASE * span + r - g;
         endcase
         hue_fx = (((DEG_PER_SECTOR * numer) << HUE_FRAC) + span / 2) / span;
         if (hue_fx >= (DEG_FULL << HUE_FRAC)) hue_fx -= (DEG_FULL << HUE_FRAC);
         res.hue = hue_fx[HUE_W-1:0];
         res.sat = sat_fx[CHAN_W-1:0];
         res.undef = 1'b0;
      end
      return res;
   endfunction

   function automatic pixel_type random_pixel();
      pixel_type px;
      int        v, lo_v, pick;
      px.red = CHAN_W'($urandom_range(0, 255));
      px.green = CHAN_W'($urandom_range(0, 255));
      px.blue = CHAN_W'($urandom_range(0, 255));
      case ($urandom_range(0, 9))
         4: begin
            v = $urandom_range(0, 9) == 0 ? 0 : $urandom_range(1, 255);
            px = '{v[7:0], v[7:0], v[7:0]};
         end
         5: begin
            // two channels share the max
            v = $urandom_range(1, 255);
            lo_v = $urandom_range(0, v);
            pick = $urandom_range(0, 2);
            if (pick == 0) px = '{v[7:0], v[7:0], lo_v[7:0]};
            else if (pick == 1) px = '{v[7:0], lo_v[7:0], v[7:0]};
            else px = '{lo_v[7:0], v[7:0], v[7:0]};
         end
         6: begin
            // near gray: each channel within 2 of a shared level
            v = $urandom_range(2, 253);
            px.red = CHAN_W'(v + $urandom_range(0, 4) - 2);
            px.green = CHAN_W'(v + $urandom_range(0, 4) - 2);
            px.blue = CHAN_W'(v + $urandom_range(0, 4) - 2);
         end
         7: begin
            px.red = CHAN_W'($urandom_range(0, 3));
            px.green = CHAN_W'($urandom_range(0, 3));
            px.blue = CHAN_W'($urandom_range(0, 3));
         end
         8: begin
            pick = $urandom_range(0, 2);
            if (pick == 0) px.red = 8'd255;
            else if (pick == 1) px.green = 8'd255;
            else px.blue = 8'd255;
         end
         9: begin
            pick = $urandom_range(0, 2);
            if (pick == 0) px.red = 8'd0;
            else if (pick == 1) px.green = 8'd0;
            else px.blue = 8'd0;
         end
         default: ;
      endcase
      return px;
   endfunction

   task automatic check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin : driver
      bit        offer;
      pixel_type px;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            expected_hsv.push_back(predict_hsv('{req_red_in, req_green_in, req_blue_in}));
            pixels_sent++;
         end
         tail_quiet <= (pixel_queue.size() < TAIL_QUIET);
         if (!req_valid || req_ready) begin
            offer = 1'b0;
            if (send_gap > 0) begin
               send_gap--;
            end else if (pixel_queue.size() > 0) begin
               px = pixel_queue.pop_front();
               offer = 1'b1;
               req_red_in <= px.red;
               req_green_in <= px.green;
               req_blue_in <= px.blue;
               if (!tail_quiet && $urandom_range(0, 11) == 0) send_gap = $urandom_range(1, 8);
            end
            req_valid <= offer;
         end
      end
   end

   always @(posedge clock) begin : monitor
      hsv_result_type want;
      bit             ready_next;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            results_seen++;
            if (rsp_hue_undefined) undefined_seen++;
            if (expected_hsv.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual hue %0d sat %0d val %0d",
                        $time, rsp_hue_out, rsp_saturation_out, rsp_value_out);
               mismatches++;
            end else begin
               want = expected_hsv.pop_front();
               check_field("hue", 32'(want.hue), 32'(rsp_hue_out));
               check_field("saturation", 32'(want.sat), 32'(rsp_saturation_out));
               check_field("value", 32'(want.val), 32'(rsp_value_out));
               check_field("hue_undefined", 32'(want.undef), 32'(rsp_hue_undefined));
            end
         end
         ready_next = 1'b1;
         if (hold_left > 0) begin
            hold_left--;
            ready_next = 1'b0;
         end else if (!long_hold_done && pixels_sent >= HOLD_AFTER) begin
            long_hold_done = 1'b1;
            hold_left = LONG_HOLD - 1;
            ready_next = 1'b0;
         end else if (!tail_quiet && $urandom_range(0, 9) == 0) begin
            hold_left = $urandom_range(0, 7);
            ready_next = 1'b0;
         end
         rsp_ready <= ready_next;
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= MAX_CYCLES) begin
         $display("%0t: timeout, %0d of %0d pixels sent", $time, pixels_sent, pixels_total);
         $display("end of test: mismatches");
         $finish;
      end
   end

   initial begin : stimulus
      pixel_type directed[$];
      directed = '{
         '{8'd0, 8'd0, 8'd0},       '{8'd255, 8'd255, 8'd255}, '{8'd128, 8'd128, 8'd128},
         '{8'd1, 8'd1, 8'd1},       '{8'd255, 8'd0, 8'd0},     '{8'd0, 8'd255, 8'd0},
         '{8'd0, 8'd0, 8'd255},     '{8'd255, 8'd0, 8'd1},     '{8'd255, 8'd255, 8'd0},
         '{8'd0, 8'd255, 8'd255},   '{8'd255, 8'd0, 8'd255},   '{8'd1, 8'd0, 8'd0},
         '{8'd0, 8'd1, 8'd0},       '{8'd0, 8'd0, 8'd1},       '{8'd255, 8'd254, 8'd0},
         '{8'd254, 8'd255, 8'd0},   '{8'd0, 8'd254, 8'd255},   '{8'd3, 8'd2, 8'd2},
         '{8'd200, 8'd100, 8'd50},  '{8'd100, 8'd200, 8'd150}, '{8'd50, 8'd60, 8'd220},
         '{8'd255, 8'd1, 8'd0},     '{8'd170, 8'd85, 8'd170},  '{8'd254, 8'd1, 8'd255}
      };
      foreach (directed[i]) pixel_queue.push_back(directed[i]);
      repeat (RANDOM_PIX) pixel_queue.push_back(random_pixel());
      pixels_total = pixel_queue.size();

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      while (pixels_sent < pixels_total || expected_hsv.size() != 0) @(posedge clock);
      repeat (DRAIN_CYC) @(posedge clock);
      if (expected_hsv.size() != 0) begin
         $display("%0t: %0d results never arrived", $time, expected_hsv.size());
         mismatches++;
      end
      $display("%0d pixels converted, %0d results checked, %0d with undefined hue",
               pixels_sent, results_seen, undefined_seen);
      $display("random idle on both ports, one %0d-cycle output stall", LONG_HOLD);
      if (mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
